/* hw/rtl/rhmc_pkg.sv */
// shared types, codes and reset values for the ramped h-bridge motor controller
`default_nettype none

package rhmc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_FWD   = 2'd0,
        MODE_BCK   = 2'd1,
        MODE_BRAKE = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCESS_INTERVAL = 3'd0,
        CFG_RAMP_STEP        = 3'd1,
        CFG_MAX_DUTY         = 3'd2,
        CFG_BRAKE_DUTY       = 3'd3,
        CFG_CURRENT_LIMIT    = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] RST_PROCESS_INTERVAL = 16'd100;
    localparam logic [6:0]  RST_RAMP_STEP        = 7'd5;
    localparam logic [6:0]  RST_MAX_DUTY         = 7'd85;
    localparam logic [6:0]  RST_BRAKE_DUTY       = 7'd99;
    localparam logic [11:0] RST_CURRENT_LIMIT    = 12'd100;

    typedef struct packed {
        logic [15:0] process_interval;
        logic [6:0]  ramp_step;
        logic [6:0]  max_duty;
        logic [6:0]  brake_duty;
        logic [11:0] current_limit;
    } t_cfg;

    typedef struct packed {
        logic [16:0]        tick_count;
        t_mode              run_mode;
        t_mode              pending_mode;
        logic signed [7:0]  target_speed;
        logic signed [7:0]  ramped_speed;
        logic [6:0]         fwd_compare;
        logic [6:0]         bck_compare;
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/rhmc_if.sv */
// request and result channel interfaces of the motor controller
`default_nettype none

interface rhmc_req_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic signed [7:0] target;
    logic [11:0]       sense_one;
    logic [11:0]       sense_two;

    modport source (output valid, output action, output target, output sense_one,
                    output sense_two, input ready);
    modport sink   (input valid, input action, input target, input sense_one,
                    input sense_two, output ready);
endinterface

interface rhmc_rsp_if;
    logic              valid;
    logic              ready;
    logic [6:0]        fwd_duty;
    logic [6:0]        bck_duty;
    logic [1:0]        mode;
    logic signed [7:0] speed_now;

    modport source (output valid, output fwd_duty, output bck_duty, output mode,
                    output speed_now, input ready);
    modport sink   (input valid, input fwd_duty, input bck_duty, input mode,
                    input speed_now, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rhmc_core.sv */
// next-state logic: target handling, tick counting, ramp and brake step
`default_nettype none

module rhmc_core
    import rhmc_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic              i_action,
    input  logic signed [7:0] i_target,
    input  logic [11:0]       i_sense_one,
    input  logic [11:0]       i_sense_two,
    output t_state            o_state
);

    logic [16:0]       tick_inc;
    logic              step_due;
    logic              is_drive;
    logic              is_brake;
    logic              can_leave;
    t_mode             want;
    logic signed [8:0] max_s;
    logic signed [8:0] neg_max;
    logic signed [8:0] step_s;
    logic signed [8:0] neg_step;
    logic signed [8:0] tgt9;
    logic signed [8:0] tgt_c;
    logic signed [7:0] base;
    logic signed [8:0] diff;
    logic signed [8:0] diff_c;
    logic signed [8:0] s;
    logic signed [8:0] neg_s;
    logic [6:0]        ramp_fwd;
    logic [6:0]        ramp_bck;
    logic signed [8:0] ramp_spd;

    assign tick_inc  = i_state.tick_count + 17'd1;
    assign step_due  = tick_inc > {1'b0, i_cfg.process_interval};
    assign is_drive  = (i_state.run_mode == MODE_FWD) || (i_state.run_mode == MODE_BCK);
    assign is_brake  = i_state.run_mode == MODE_BRAKE;
    assign can_leave = (i_state.pending_mode != MODE_BRAKE)
                     && (i_sense_one <= i_cfg.current_limit)
                     && (i_sense_two <= i_cfg.current_limit);

    assign max_s    = $signed({2'b00, i_cfg.max_duty});
    assign neg_max  = -max_s;
    assign step_s   = $signed({2'b00, i_cfg.ramp_step});
    assign neg_step = -step_s;

    // direction follows the raw sign, before saturation
    assign want  = (i_target > 8'sd0) ? MODE_FWD :
                   (i_target < 8'sd0) ? MODE_BCK : MODE_BRAKE;
    assign tgt9  = 9'(i_target);
    assign tgt_c = (tgt9 > max_s) ? max_s : (tgt9 < neg_max) ? neg_max : tgt9;

    // leaving the brake ramps from a standing start
    assign base   = is_drive ? i_state.ramped_speed : 8'sd0;
    assign diff   = 9'(i_state.target_speed) - 9'(base);
    assign diff_c = (diff > step_s) ? step_s : (diff < neg_step) ? neg_step : diff;
    assign s      = 9'(base) + diff_c;
    assign neg_s  = -s;

    assign ramp_fwd = (s > 9'sd0) ? ((s > max_s) ? i_cfg.max_duty : s[6:0]) : 7'd0;
    assign ramp_bck = (s > 9'sd0) ? 7'd0 :
                      ((neg_s > max_s) ? i_cfg.max_duty : neg_s[6:0]);
    assign ramp_spd = (s > max_s) ? max_s : (s < neg_max) ? neg_max : s;

    always_comb begin
        o_state = i_state;
        if (i_action) begin
            o_state.target_speed = tgt_c[7:0];
            if (want != i_state.run_mode) begin
                if (is_drive) begin
                    o_state.run_mode     = MODE_BRAKE;
                    o_state.pending_mode = want;
                end else if (is_brake) begin
                    o_state.pending_mode = want;
                end
            end
        end else begin
            o_state.tick_count = tick_inc;
            if (step_due) begin
                o_state.tick_count = '0;
                if (is_drive) begin
                    o_state.fwd_compare  = ramp_fwd;
                    o_state.bck_compare  = ramp_bck;
                    o_state.ramped_speed = ramp_spd[7:0];
                end else if (is_brake) begin
                    o_state.fwd_compare  = i_cfg.brake_duty;
                    o_state.bck_compare  = i_cfg.brake_duty;
                    o_state.ramped_speed = 8'sd0;
                    if (can_leave) begin
                        o_state.run_mode     = i_state.pending_mode;
                        o_state.fwd_compare  = ramp_fwd;
                        o_state.bck_compare  = ramp_bck;
                        o_state.ramped_speed = ramp_spd[7:0];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ramped_hbridge_motor_controller.sv */
// top level: config registers, request register, controller state and result channel
`default_nettype none

// Ramped H-bridge controller with active brake. Every request (a millisecond tick or a new
// signed target) yields exactly one result carrying both PWM compare values, the run mode
// and the ramped speed. A request is taken into an input register; when the result slot is
// free or being emptied, the combinational next-state logic updates the controller state,
// which drives the result port directly. One request per cycle is sustained while results
// are taken, and one further request is held while a result waits to be taken.
// Configuration writes (interval, ramp step, max duty, brake duty, current limit) are
// meant for idle periods only; an index beyond the register list is ignored.
module ramped_hbridge_motor_controller
    import rhmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rhmc_req_if.sink                   i_req,
    rhmc_rsp_if.source                 o_rsp
);

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            n_state;
    logic              r_in_valid;
    logic              r_in_action;
    logic signed [7:0] r_in_target;
    logic [11:0]       r_in_sense_one;
    logic [11:0]       r_in_sense_two;
    logic              r_out_valid;
    logic              advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.process_interval <= RST_PROCESS_INTERVAL;
            r_cfg.ramp_step        <= RST_RAMP_STEP;
            r_cfg.max_duty         <= RST_MAX_DUTY;
            r_cfg.brake_duty       <= RST_BRAKE_DUTY;
            r_cfg.current_limit    <= RST_CURRENT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROCESS_INTERVAL: r_cfg.process_interval <= i_cfg_data[15:0];
                CFG_RAMP_STEP:        r_cfg.ramp_step        <= i_cfg_data[6:0];
                CFG_MAX_DUTY:         r_cfg.max_duty         <= i_cfg_data[6:0];
                CFG_BRAKE_DUTY:       r_cfg.brake_duty       <= i_cfg_data[6:0];
                CFG_CURRENT_LIMIT:    r_cfg.current_limit    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // the held request moves on whenever the result slot is free or being emptied
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_action    <= i_req.action;
            r_in_target    <= i_req.target;
            r_in_sense_one <= i_req.sense_one;
            r_in_sense_two <= i_req.sense_two;
        end
    end

    rhmc_core u_core (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_action    (r_in_action),
        .i_target    (r_in_target),
        .i_sense_one (r_in_sense_one),
        .i_sense_two (r_in_sense_two),
        .o_state     (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tick_count   <= '0;
            r_state.run_mode     <= MODE_BRAKE;
            r_state.pending_mode <= MODE_BRAKE;
            r_state.target_speed <= '0;
            r_state.ramped_speed <= '0;
            r_state.fwd_compare  <= '0;
            r_state.bck_compare  <= '0;
            r_out_valid          <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // state only changes when the result slot is free or being emptied, so it doubles as the result payload
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.fwd_duty  = r_state.fwd_compare;
    assign o_rsp.bck_duty  = r_state.bck_compare;
    assign o_rsp.mode      = r_state.run_mode;
    assign o_rsp.speed_now = r_state.ramped_speed;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking testbench for the ramped h-bridge motor controller
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rhmc_pkg::*;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_TARGET = 1'b1;
    localparam int   STALL_LIMIT = 4000;
    localparam int   MAX_REPORTS = 10;

    typedef struct packed {
        logic [6:0]        fwd;
        logic [6:0]        bck;
        logic [1:0]        md;
        logic signed [7:0] spd;
    } duty_rec_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rhmc_req_if req_ch ();
    rhmc_rsp_if rsp_ch ();

    ramped_hbridge_motor_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers and controller state
    logic [15:0] ivl;
    logic [6:0]  rstep;
    logic [6:0]  dmax;
    logic [6:0]  dbrake;
    logic [11:0] ilim;
    logic [16:0] tick_cnt;
    t_mode       run_md;
    t_mode       pend_md;
    int          tgt_spd;
    int          ramp_spd;
    logic [6:0]  fwd_cmp;
    logic [6:0]  bck_cmp;

    duty_rec_t duty_exp_q[$];
    int        mismatch_cnt = 0;
    int        idle_cycles = 0;
    bit        req_gaps_on = 1'b1;
    bit        rsp_gaps_on = 1'b1;
    int        rsp_hold_req = 0;
    int        rsp_stall_left = 0;

    function automatic int clamp_sym(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void ramp_toward();
        int lim;
        int diff;
        int s;
        lim  = int'(dmax);
        diff = clamp_sym(tgt_spd - ramp_spd, int'(rstep));
        s    = ramp_spd + diff;
        if (s > 0) begin
            fwd_cmp = 7'((s > lim) ? lim : s);
            bck_cmp = '0;
        end else begin
            fwd_cmp = '0;
            bck_cmp = 7'((-s > lim) ? lim : -s);
        end
        ramp_spd = clamp_sym(s, lim);
    endfunction

    function automatic duty_rec_t predict_bridge(input logic act, input logic signed [7:0] tgt,
                                                 input logic [11:0] s1, input logic [11:0] s2);
        duty_rec_t rec;
        t_mode     want;
        int        t;
        t = int'(tgt);
        if (act == ACT_TARGET) begin
            // direction follows the raw sign, before saturation
            want = (t > 0) ? MODE_FWD : ((t < 0) ? MODE_BCK : MODE_BRAKE);
            tgt_spd = clamp_sym(t, int'(dmax));
            if (want != run_md) begin
                if (run_md == MODE_FWD || run_md == MODE_BCK) run_md = MODE_BRAKE;
                pend_md = want;
            end
        end else begin
            tick_cnt = tick_cnt + 17'd1;
            if (tick_cnt > {1'b0, ivl}) begin
                tick_cnt = '0;
                if (run_md == MODE_BRAKE) begin
                    fwd_cmp  = dbrake;
                    bck_cmp  = dbrake;
                    ramp_spd = 0;
                    if (pend_md != MODE_BRAKE && s1 <= ilim && s2 <= ilim) begin
                        run_md = pend_md;
                        ramp_toward();
                    end
                end else begin
                    ramp_toward();
                end
            end
        end
        rec.fwd = fwd_cmp;
        rec.bck = bck_cmp;
        rec.md  = run_md;
        rec.spd = 8'(ramp_spd);
        return rec;
    endfunction

    function automatic void note_fail(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("%0t %s", $realtime, msg);
    endfunction

    function automatic logic signed [7:0] rand_target();
        case ($urandom_range(0, 9))
            0: return 8'sd127;
            1: return -8'sd128;
            2: return 8'sd0;
            3: return 8'sd1;
            4: return -8'sd1;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [11:0] rand_sense();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 12'($urandom_range(0, int'(ilim)));
        if (r < 85 || ilim == 12'hFFF) return 12'($urandom());
        return 12'($urandom_range(int'(ilim) + 1, 4095));
    endfunction

    // one request: optional gap, then hold valid until taken
    task automatic send_req(input logic act, input logic signed [7:0] tgt,
                            input logic [11:0] s1, input logic [11:0] s2);
        int gap;
        gap = req_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.target    <= tgt;
        req_ch.sense_one <= s1;
        req_ch.sense_two <= s2;
        do @(posedge i_clk); while (!req_ch.ready);
        duty_exp_q.push_back(predict_bridge(act, tgt, s1, s2));
    endtask

    task automatic send_random_req();
        if ($urandom_range(0, 99) < 12) begin
            send_req(ACT_TARGET, rand_target(), 12'($urandom()), 12'($urandom()));
        end else begin
            send_req(ACT_TICK, 8'($urandom()), rand_sense(), rand_sense());
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (duty_exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PROCESS_INTERVAL: ivl    = data;
            CFG_RAMP_STEP:        rstep  = data[6:0];
            CFG_MAX_DUTY:         dmax   = data[6:0];
            CFG_BRAKE_DUTY:       dbrake = data[6:0];
            CFG_CURRENT_LIMIT:    ilim   = data[11:0];
            default: ;
        endcase
    endtask

    // register values carry random junk above their width
    task automatic cfg_all(input logic [15:0] p_ivl, input logic [6:0] p_step,
                           input logic [6:0] p_max, input logic [6:0] p_brake,
                           input logic [11:0] p_lim);
        logic [15:0] junk;
        junk = 16'($urandom());
        cfg_write(CFG_PROCESS_INTERVAL, p_ivl);
        cfg_write(CFG_RAMP_STEP, {junk[15:7], p_step});
        cfg_write(CFG_MAX_DUTY, {junk[8:0], p_max});
        cfg_write(CFG_BRAKE_DUTY, {junk[12:4], p_brake});
        cfg_write(CFG_CURRENT_LIMIT, {junk[3:0], p_lim});
        cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_CURRENT_LIMIT) + 1, (1 << CFG_IDX_W) - 1)),
                  16'($urandom()));
    endtask

    task automatic test_reset_values();
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TARGET, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'hFFF, 12'hFFF);
    endtask

    task automatic test_directed_drive();
        wait_drain();
        cfg_write(CFG_PROCESS_INTERVAL, 16'h0000);
        cfg_write(CFG_RAMP_STEP, 16'hA532);
        cfg_write(CFG_MAX_DUTY, 16'hFFFF);
        cfg_write(CFG_BRAKE_DUTY, 16'hFF80);
        cfg_write(CFG_CURRENT_LIMIT, 16'hF7D0);
        send_req(ACT_TARGET, 8'sd127, 12'd0, 12'd0);
        // current above the limit keeps the brake on
        send_req(ACT_TICK, 8'sd0, 12'hFFF, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd2000, 12'd2000);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        // reversal while driving brakes at once
        send_req(ACT_TARGET, -8'sd128, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd2001);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TARGET, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TARGET, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TARGET, 8'sd1, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
    endtask

    task automatic test_special_regs();
        wait_drain();
        cfg_write(CFG_MAX_DUTY, 16'h0080);
        // nonzero target still picks a direction with a zero clamp
        send_req(ACT_TARGET, -8'sd5, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        wait_drain();
        cfg_write(CFG_RAMP_STEP, 16'h0100);
        cfg_write(CFG_MAX_DUTY, 16'h007F);
        for (int k = int'(CFG_CURRENT_LIMIT) + 1; k < (1 << CFG_IDX_W); k++) begin
            cfg_write(CFG_IDX_W'(k), 16'hFFFF);
        end
        send_req(ACT_TARGET, -8'sd100, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
        send_req(ACT_TICK, 8'sd0, 12'd0, 12'd0);
    endtask

    task automatic run_phase(input int n, input logic [15:0] p_ivl, input logic [6:0] p_step,
                             input logic [6:0] p_max, input logic [6:0] p_brake,
                             input logic [11:0] p_lim);
        wait_drain();
        cfg_all(p_ivl, p_step, p_max, p_brake, p_lim);
        req_gaps_on = ($urandom_range(0, 3) != 0);
        rsp_gaps_on = ($urandom_range(0, 3) != 0);
        repeat (n) send_random_req();
    endtask

    task automatic test_random_phases();
        logic [15:0] p_ivl;
        logic [6:0]  p_step;
        logic [11:0] p_lim;
        run_phase(60, 16'd1, 7'd1, 7'd0, 7'd0, 12'd0);
        run_phase(20, 16'hFFFF, 7'd127, 7'd127, 7'd127, 12'hFFF);
        run_phase(80, 16'd0, 7'd127, 7'd127, 7'd127, 12'hFFF);
        repeat (6) begin
            p_ivl  = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6))
                                                  : 16'($urandom_range(7, 40));
            p_step = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(1, 10))
                                                  : 7'($urandom_range(1, 127));
            p_lim  = ($urandom_range(0, 99) < 30) ? 12'hFFF : 12'($urandom());
            run_phase(70, p_ivl, p_step, 7'($urandom()), 7'($urandom()), p_lim);
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        req_gaps_on  = 1'b0;
        rsp_gaps_on  = 1'b0;
        rsp_hold_req = 250;
        repeat (40) send_random_req();
    endtask

    task automatic test_drain_pause();
        req_gaps_on = 1'b1;
        rsp_gaps_on = 1'b1;
        repeat (15) send_random_req();
        wait_drain();
        repeat (15) send_random_req();
    endtask

    // result side: random stalls plus the occasional long hold
    always @(negedge i_clk) begin
        if (rsp_hold_req > 0) begin
            rsp_stall_left = rsp_hold_req;
            rsp_hold_req   = 0;
        end else if (rsp_stall_left == 0 && rsp_gaps_on) begin
            rsp_stall_left = idle_len();
        end
        if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        duty_rec_t want_rec;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (duty_exp_q.size() == 0) begin
                note_fail("result with no request outstanding");
            end else begin
                want_rec = duty_exp_q.pop_front();
                if (rsp_ch.fwd_duty !== want_rec.fwd || rsp_ch.bck_duty !== want_rec.bck ||
                    rsp_ch.mode !== want_rec.md || rsp_ch.speed_now !== want_rec.spd) begin
                    note_fail($sformatf(
                        "mismatch exp/got fwd %0d/%0d bck %0d/%0d mode %0d/%0d speed %0d/%0d",
                        want_rec.fwd, rsp_ch.fwd_duty, want_rec.bck, rsp_ch.bck_duty,
                        want_rec.md, rsp_ch.mode, want_rec.spd, rsp_ch.speed_now));
                end
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (req_ch.valid && req_ch.ready) ||
            (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_TICK;
        req_ch.target    = '0;
        req_ch.sense_one = '0;
        req_ch.sense_two = '0;
        rsp_ch.ready     = 1'b0;
        ivl      = RST_PROCESS_INTERVAL;
        rstep    = RST_RAMP_STEP;
        dmax     = RST_MAX_DUTY;
        dbrake   = RST_BRAKE_DUTY;
        ilim     = RST_CURRENT_LIMIT;
        tick_cnt = '0;
        run_md   = MODE_BRAKE;
        pend_md  = MODE_BRAKE;
        tgt_spd  = 0;
        ramp_spd = 0;
        fwd_cmp  = '0;
        bck_cmp  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_drive();
        test_special_regs();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        wait_drain();
        repeat (10) @(posedge i_clk);

        if (mismatch_cnt == 0 && duty_exp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/rhmc_pkg.sv
hw/rtl/rhmc_if.sv
hw/rtl/rhmc_core.sv
hw/rtl/ramped_hbridge_motor_controller.sv
tb/sv/tb_top.sv
